// File: sv/bad_pkg.sv
// Shared types and constants for the box average downscaler.
// Holds payload structs, register indexes and default sizes; no dependencies.
package bad_pkg;

  // Default sizes for the top level parameters.
  localparam int DefMaxOutColumns = 1024;
  localparam int DefMaxZoom       = 16;
  localparam int DefChannels      = 4;

  // Fixed pixel layout: four 8-bit lanes in a 32-bit word.
  localparam int PixW     = 32;
  localparam int ChanBits = 8;

  // Configuration port layout.
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 16;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ZOOM     = 4'd0,
    CFG_ROW_LEN  = 4'd1,
    CFG_OUT_COLS = 4'd2,
    CFG_OUT_ROWS = 4'd3
  } cfg_idx_e;

  // Input item.
  typedef struct packed {
    logic            frame_start;
    logic [PixW-1:0] pixel_in;
  } pix_in_t;

  // Result item.
  typedef struct packed {
    logic            frame_done;
    logic [PixW-1:0] pixel_out;
  } pix_out_t;

  // Configuration write.
  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  // Per-item control flags from the position tracker.
  typedef struct packed {
    logic covered;
    logic first;
    logic last;
    logic done;
  } step_t;

endpackage

// File: sv/bad_stream_if.sv
// Valid/ready channel carrying one payload item per handshake.
// The payload type comes in as a parameter; uses no package directly.
interface bad_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/box_average_downscaler.sv
// Box average downscaler, top level.
// Pixels enter on pix_in_i (valid/ready, payload pixel_in and frame_start) in
// raster order. Each zoom-by-zoom block of pixels yields one averaged pixel on
// pix_out_o, with frame_done set on the last block of the frame. Registers are
// written on cfg_i (index, data; always ready); the user must write them only
// while no item is in flight, which the block itself does not enforce.
// Sequence: an item is taken and its column sum is read from the sum memory;
// the next cycle adds the pixel and writes the entry back. An item that closes
// a block then runs the per-channel dividers, one quotient bit a cycle over the
// SUM_W-bit sum, and its result goes to the output register when they finish.
// One item is in work at a time, which keeps the memory access order simple.
// The result sits in an output register, so the next item is taken while it
// waits; if the receiver stalls and a second result is ready, the divider
// holds it until the output register frees up.
// Reset clears the position counters and loads the default registers; the
// sum memory needs no clearing, since the first pixel of a block writes it.
module box_average_downscaler import bad_pkg::*; #(
  parameter int MAX_OUT_COLUMNS = DefMaxOutColumns,
  parameter int MAX_ZOOM        = DefMaxZoom,
  parameter int CHANNELS        = DefChannels
) (
  input  logic clk_i,
  input  logic rst_ni,
  bad_stream_if.sink   pix_in_i,
  bad_stream_if.source pix_out_o,
  bad_stream_if.sink   cfg_i
);

  localparam int ZW    = $clog2(MAX_ZOOM + 1);
  localparam int BCW   = $clog2(MAX_OUT_COLUMNS + 1);
  localparam int AW    = (MAX_OUT_COLUMNS > 1) ? $clog2(MAX_OUT_COLUMNS) : 1;
  localparam int SUM_W = $clog2(MAX_ZOOM * MAX_ZOOM * 255 + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPD,
    S_DIV
  } state_e;

  state_e state_q;

  logic [4:0]  zoom_q;
  logic [12:0] row_len_q;
  logic [10:0] out_cols_q;
  logic [12:0] out_rows_q;

  logic [ZW-1:0]  zoom_eff;
  logic [12:0]    row_len_eff;
  logic [BCW-1:0] out_cols_eff;

  logic                      accept;
  logic [PixW-1:0]           pixel_q;
  logic [AW-1:0]             rd_addr;
  logic [AW-1:0]             wr_addr;
  step_t                     step;
  logic [CHANNELS*SUM_W-1:0] sums;
  logic                      div_start;
  logic                      div_done;
  logic [PixW-1:0]           div_pixel;
  logic                      out_free;
  logic                      out_load;

  logic            out_valid_q;
  logic [PixW-1:0] out_pixel_q;
  logic            out_done_q;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zoom_q     <= 5'd1;
      row_len_q  <= 13'd640;
      out_cols_q <= 11'd320;
      out_rows_q <= 13'd240;
    end else if (cfg_i.valid) begin
      case (cfg_i.payload.index)
        CFG_ZOOM:     zoom_q     <= cfg_i.payload.data[4:0];
        CFG_ROW_LEN:  row_len_q  <= cfg_i.payload.data[12:0];
        CFG_OUT_COLS: out_cols_q <= cfg_i.payload.data[10:0];
        CFG_OUT_ROWS: out_rows_q <= cfg_i.payload.data[12:0];
        default: ;
      endcase
    end
  end

  // Effective values: zoom clamped to 1..MAX_ZOOM, columns to MAX_OUT_COLUMNS.
  always_comb begin
    if (zoom_q == '0) begin
      zoom_eff = ZW'(1);
    end else if (32'(zoom_q) > 32'(MAX_ZOOM)) begin
      zoom_eff = ZW'(MAX_ZOOM);
    end else begin
      zoom_eff = ZW'(zoom_q);
    end
    row_len_eff = (row_len_q == '0) ? 13'd1 : row_len_q;
    if (32'(out_cols_q) > 32'(MAX_OUT_COLUMNS)) begin
      out_cols_eff = BCW'(MAX_OUT_COLUMNS);
    end else begin
      out_cols_eff = BCW'(out_cols_q);
    end
  end

  assign accept         = pix_in_i.valid && pix_in_i.ready;
  assign pix_in_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pixel_q <= pix_in_i.payload.pixel_in;
    end
  end

  bad_pos #(
    .MAX_OUT_COLUMNS(MAX_OUT_COLUMNS),
    .MAX_ZOOM       (MAX_ZOOM)
  ) u_pos (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .frame_start_i(pix_in_i.payload.frame_start),
    .zoom_i       (zoom_eff),
    .row_len_i    (row_len_eff),
    .out_cols_i   (out_cols_eff),
    .out_rows_i   (out_rows_q),
    .rd_addr_o    (rd_addr),
    .wr_addr_o    (wr_addr),
    .step_o       (step)
  );

  bad_sum_mem #(
    .MAX_OUT_COLUMNS(MAX_OUT_COLUMNS),
    .CHANNELS       (CHANNELS),
    .SUM_W          (SUM_W)
  ) u_mem (
    .clk_i    (clk_i),
    .rd_en_i  (accept),
    .rd_addr_i(rd_addr),
    .wr_en_i  ((state_q == S_UPD) && step.covered),
    .wr_addr_i(wr_addr),
    .first_i  (step.first),
    .pixel_i  (pixel_q),
    .sums_o   (sums)
  );

  assign div_start = (state_q == S_UPD) && step.covered && step.last;

  bad_div #(
    .CHANNELS(CHANNELS),
    .MAX_ZOOM(MAX_ZOOM),
    .SUM_W   (SUM_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .sums_i (sums),
    .zoom_i (zoom_eff),
    .done_o (div_done),
    .pixel_o(div_pixel)
  );

  assign out_free = !out_valid_q || pix_out_o.ready;
  assign out_load = (state_q == S_DIV) && div_done && out_free;

  // Sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_pixel_q <= '0;
      out_done_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_pixel_q <= div_pixel;
        out_done_q  <= step.done;
      end else if (out_valid_q && pix_out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          state_q <= div_start ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign pix_out_o.valid              = out_valid_q;
  assign pix_out_o.payload.pixel_out  = out_pixel_q;
  assign pix_out_o.payload.frame_done = out_done_q;

endmodule

// File: sv/bad_pos.sv
// Raster position tracker: input column/row, phases within a block and block column.
// Produces the sum memory address and per-item flags. Depends on bad_pkg.
module bad_pos import bad_pkg::*; #(
  parameter int MAX_OUT_COLUMNS = DefMaxOutColumns,
  parameter int MAX_ZOOM        = DefMaxZoom,
  localparam int ZW  = $clog2(MAX_ZOOM + 1),
  localparam int BCW = $clog2(MAX_OUT_COLUMNS + 1),
  localparam int AW  = (MAX_OUT_COLUMNS > 1) ? $clog2(MAX_OUT_COLUMNS) : 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic           frame_start_i,
  input  logic [ZW-1:0]  zoom_i,
  input  logic [12:0]    row_len_i,
  input  logic [BCW-1:0] out_cols_i,
  input  logic [12:0]    out_rows_i,
  output logic [AW-1:0]  rd_addr_o,
  output logic [AW-1:0]  wr_addr_o,
  output step_t          step_o
);

  logic [12:0]    in_col_q, in_col_d, col_c;
  logic [12:0]    in_row_q, in_row_d, row_c;
  logic [ZW-1:0]  col_ph_q, col_ph_d, cph_c;
  logic [ZW-1:0]  row_ph_q, row_ph_d, rph_c;
  logic [BCW-1:0] blk_col_q, blk_col_d, bc_c;
  logic [AW-1:0]  addr_q;
  step_t          step_q, step_d;

  // Frame start clears the position before this pixel is used.
  always_comb begin
    col_c = frame_start_i ? '0 : in_col_q;
    row_c = frame_start_i ? '0 : in_row_q;
    cph_c = frame_start_i ? '0 : col_ph_q;
    rph_c = frame_start_i ? '0 : row_ph_q;
    bc_c  = frame_start_i ? '0 : blk_col_q;
  end

  assign rd_addr_o = bc_c[AW-1:0];

  // Flags for this pixel.
  always_comb begin
    step_d.covered = (bc_c < out_cols_i) && (row_c < out_rows_i);
    step_d.first   = (rph_c == '0) && (cph_c == '0);
    step_d.last    = ((ZW+1)'(rph_c) + 1'b1 == (ZW+1)'(zoom_i)) &&
                     ((ZW+1)'(cph_c) + 1'b1 == (ZW+1)'(zoom_i));
    step_d.done    = (14'(row_c) + 14'd1 == 14'(out_rows_i)) &&
                     ((BCW+1)'(bc_c) + 1'b1 == (BCW+1)'(out_cols_i));
  end

  // Advance the position; the row and block counters stop past the covered area.
  always_comb begin
    in_col_d  = col_c;
    in_row_d  = row_c;
    col_ph_d  = cph_c;
    row_ph_d  = rph_c;
    blk_col_d = bc_c;
    if (14'(col_c) + 14'd1 >= 14'(row_len_i)) begin
      in_col_d  = '0;
      col_ph_d  = '0;
      blk_col_d = '0;
      if (row_c < out_rows_i) begin
        if ((ZW+1)'(rph_c) + 1'b1 >= (ZW+1)'(zoom_i)) begin
          row_ph_d = '0;
          in_row_d = row_c + 13'd1;
        end else begin
          row_ph_d = rph_c + 1'b1;
        end
      end
    end else begin
      in_col_d = col_c + 13'd1;
      if ((ZW+1)'(cph_c) + 1'b1 >= (ZW+1)'(zoom_i)) begin
        col_ph_d = '0;
        if (bc_c < out_cols_i) begin
          blk_col_d = bc_c + 1'b1;
        end
      end else begin
        col_ph_d = cph_c + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      col_ph_q  <= '0;
      row_ph_q  <= '0;
      blk_col_q <= '0;
      step_q    <= '0;
    end else if (accept_i) begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      col_ph_q  <= col_ph_d;
      row_ph_q  <= row_ph_d;
      blk_col_q <= blk_col_d;
      step_q    <= step_d;
    end
  end

  // Write address for the update cycle that follows the item.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      addr_q <= bc_c[AW-1:0];
    end
  end

  assign wr_addr_o = addr_q;
  assign step_o    = step_q;

endmodule

// File: sv/bad_sum_mem.sv
// Column sum memory with read-modify-write: one entry of channel sums per block column.
// The read is registered; the update adds the pixel or restarts the sum. Uses bad_pkg.
module bad_sum_mem import bad_pkg::*; #(
  parameter int MAX_OUT_COLUMNS = DefMaxOutColumns,
  parameter int CHANNELS        = DefChannels,
  parameter int SUM_W           = 16,
  localparam int AW = (MAX_OUT_COLUMNS > 1) ? $clog2(MAX_OUT_COLUMNS) : 1,
  localparam int W  = CHANNELS * SUM_W
) (
  input  logic            clk_i,
  input  logic            rd_en_i,
  input  logic [AW-1:0]   rd_addr_i,
  input  logic            wr_en_i,
  input  logic [AW-1:0]   wr_addr_i,
  input  logic            first_i,
  input  logic [PixW-1:0] pixel_i,
  output logic [W-1:0]    sums_o
);

  logic [W-1:0] mem [MAX_OUT_COLUMNS];
  logic [W-1:0] rd_q;

  // Synchronous memory; a read and a write never target the same cycle.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
    if (wr_en_i) begin
      mem[wr_addr_i] <= sums_o;
    end
  end

  // Updated sums: the first pixel of a block overwrites the entry.
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      sums_o[c*SUM_W +: SUM_W] = first_i ?
          SUM_W'(pixel_i[c*ChanBits +: ChanBits]) :
          rd_q[c*SUM_W +: SUM_W] + SUM_W'(pixel_i[c*ChanBits +: ChanBits]);
    end
  end

endmodule

// File: sv/bad_div.sv
// Per-channel restoring dividers, one quotient bit per cycle, with round-half-even.
// Divides each block sum by zoom squared and packs the 8-bit means. Uses bad_pkg.
module bad_div import bad_pkg::*; #(
  parameter int CHANNELS = DefChannels,
  parameter int MAX_ZOOM = DefMaxZoom,
  parameter int SUM_W    = 16,
  localparam int ZW = $clog2(MAX_ZOOM + 1),
  localparam int DW = $clog2(MAX_ZOOM * MAX_ZOOM + 1),
  localparam int CW = $clog2(SUM_W + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [CHANNELS*SUM_W-1:0] sums_i,
  input  logic [ZW-1:0]             zoom_i,
  output logic                      done_o,
  output logic [PixW-1:0]           pixel_o
);

  logic [CW-1:0]    cnt_q;
  logic [DW-1:0]    div_q;
  logic [SUM_W-1:0] num_q [CHANNELS];
  logic [DW-1:0]    rem_q [CHANNELS];
  logic [DW:0]      trial [CHANNELS];
  logic             qbit  [CHANNELS];
  logic [DW-1:0]    rem_n [CHANNELS];
  logic             up    [CHANNELS];

  // One restoring step per channel.
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      trial[c] = {rem_q[c], num_q[c][SUM_W-1]};
      qbit[c]  = trial[c] >= {1'b0, div_q};
      rem_n[c] = qbit[c] ? DW'(trial[c] - {1'b0, div_q}) : trial[c][DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(SUM_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Quotient shifts in where the numerator shifts out.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= DW'(zoom_i) * DW'(zoom_i);
      for (int c = 0; c < CHANNELS; c++) begin
        num_q[c] <= sums_i[c*SUM_W +: SUM_W];
        rem_q[c] <= '0;
      end
    end else if (cnt_q != '0) begin
      for (int c = 0; c < CHANNELS; c++) begin
        num_q[c] <= {num_q[c][SUM_W-2:0], qbit[c]};
        rem_q[c] <= rem_n[c];
      end
    end
  end

  assign done_o = (cnt_q == '0);

  // Round to nearest, ties to even; unused lanes read as zero.
  always_comb begin
    pixel_o = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      up[c] = ({rem_q[c], 1'b0} > {1'b0, div_q}) ||
              (({rem_q[c], 1'b0} == {1'b0, div_q}) && num_q[c][0]);
      pixel_o[c*ChanBits +: ChanBits] = num_q[c][ChanBits-1:0] + ChanBits'(up[c]);
    end
  end

endmodule
